>>> hw/rtl/boc_pkg.sv
// Opcode, error and configuration register codes for the bytecode operand checker.
package boc_pkg;

    localparam int unsigned CmdWidth = 8;
    localparam int unsigned ErrWidth = 6;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth = 17;

    localparam logic [31:0] NO_TRY_TARGET = 32'hFFFF_FFFF;

    localparam logic [CfgIndexWidth-1:0] CFG_REGISTER_COUNT    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_CONSTANT_COUNT    = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_FUNCTION_COUNT    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_INSTRUCTION_COUNT = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_OWN_UPVALUE_COUNT = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_OWN_IS_VARARG     = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CFG_BINDINGS_PRESENT  = 3'd6;

    localparam logic [CmdWidth-1:0] OP_MOV             = 8'd0;
    localparam logic [CmdWidth-1:0] OP_LOADK           = 8'd1;
    localparam logic [CmdWidth-1:0] OP_ADD             = 8'd2;
    localparam logic [CmdWidth-1:0] OP_STRCONCAT       = 8'd12;
    localparam logic [CmdWidth-1:0] OP_ADDIMM          = 8'd13;
    localparam logic [CmdWidth-1:0] OP_SUBIMM          = 8'd14;
    localparam logic [CmdWidth-1:0] OP_INC             = 8'd15;
    localparam logic [CmdWidth-1:0] OP_DEC             = 8'd16;
    localparam logic [CmdWidth-1:0] OP_STRLEN          = 8'd17;
    localparam logic [CmdWidth-1:0] OP_BITNOT          = 8'd18;
    localparam logic [CmdWidth-1:0] OP_RET             = 8'd19;
    localparam logic [CmdWidth-1:0] OP_THROW           = 8'd20;
    localparam logic [CmdWidth-1:0] OP_JMP             = 8'd21;
    localparam logic [CmdWidth-1:0] OP_JMPIF           = 8'd22;
    localparam logic [CmdWidth-1:0] OP_JMPIFZERO       = 8'd23;
    localparam logic [CmdWidth-1:0] OP_JMPIFNOTZERO    = 8'd24;
    localparam logic [CmdWidth-1:0] OP_DECJNZ          = 8'd25;
    localparam logic [CmdWidth-1:0] OP_ADDDECJNZ       = 8'd26;
    localparam logic [CmdWidth-1:0] OP_SUBIMMJNZ       = 8'd27;
    localparam logic [CmdWidth-1:0] OP_ADDIMMJNZ       = 8'd28;
    localparam logic [CmdWidth-1:0] OP_CALL            = 8'd29;
    localparam logic [CmdWidth-1:0] OP_TAILCALL        = 8'd30;
    localparam logic [CmdWidth-1:0] OP_CALLCLOSURE     = 8'd31;
    localparam logic [CmdWidth-1:0] OP_TAILCALLCLOSURE = 8'd32;
    localparam logic [CmdWidth-1:0] OP_FFICALL         = 8'd33;
    localparam logic [CmdWidth-1:0] OP_CLOSURE         = 8'd34;
    localparam logic [CmdWidth-1:0] OP_GETUPVAL        = 8'd35;
    localparam logic [CmdWidth-1:0] OP_SETUPVAL        = 8'd36;
    localparam logic [CmdWidth-1:0] OP_VARARG          = 8'd37;
    localparam logic [CmdWidth-1:0] OP_NEWOBJECT       = 8'd38;
    localparam logic [CmdWidth-1:0] OP_INVOKE          = 8'd39;
    localparam logic [CmdWidth-1:0] OP_TRYBEGIN        = 8'd40;
    localparam logic [CmdWidth-1:0] OP_TRYEND          = 8'd41;
    localparam logic [CmdWidth-1:0] OP_HALT            = 8'd44;

    localparam logic [ErrWidth-1:0] ERR_NONE            = 6'd0;
    localparam logic [ErrWidth-1:0] ERR_MOV             = 6'd1;
    localparam logic [ErrWidth-1:0] ERR_LOADK           = 6'd2;
    localparam logic [ErrWidth-1:0] ERR_ARITH           = 6'd3;
    localparam logic [ErrWidth-1:0] ERR_IMM_ARITH       = 6'd4;
    localparam logic [ErrWidth-1:0] ERR_INCDEC          = 6'd5;
    localparam logic [ErrWidth-1:0] ERR_UNARY           = 6'd6;
    localparam logic [ErrWidth-1:0] ERR_RET_THROW       = 6'd7;
    localparam logic [ErrWidth-1:0] ERR_JMP_TARGET      = 6'd8;
    localparam logic [ErrWidth-1:0] ERR_COND_REG        = 6'd9;
    localparam logic [ErrWidth-1:0] ERR_JMPIF_TARGET    = 6'd10;
    localparam logic [ErrWidth-1:0] ERR_CONDJ_TARGET    = 6'd11;
    localparam logic [ErrWidth-1:0] ERR_COUNTER_REG     = 6'd12;
    localparam logic [ErrWidth-1:0] ERR_DECJNZ_TARGET   = 6'd13;
    localparam logic [ErrWidth-1:0] ERR_ADJ_REG         = 6'd14;
    localparam logic [ErrWidth-1:0] ERR_ADJ_TARGET      = 6'd15;
    localparam logic [ErrWidth-1:0] ERR_IMMJNZ_REG      = 6'd16;
    localparam logic [ErrWidth-1:0] ERR_IMMJNZ_TARGET   = 6'd17;
    localparam logic [ErrWidth-1:0] ERR_CALL_INDEX      = 6'd18;
    localparam logic [ErrWidth-1:0] ERR_CALL_WINDOW     = 6'd19;
    localparam logic [ErrWidth-1:0] ERR_CALL_ARGC       = 6'd20;
    localparam logic [ErrWidth-1:0] ERR_CALL_VARARGC    = 6'd21;
    localparam logic [ErrWidth-1:0] ERR_CLOSCALL_WINDOW = 6'd22;
    localparam logic [ErrWidth-1:0] ERR_FFI_WINDOW      = 6'd23;
    localparam logic [ErrWidth-1:0] ERR_FFI_CONST       = 6'd24;
    localparam logic [ErrWidth-1:0] ERR_FFI_SYMBOL      = 6'd25;
    localparam logic [ErrWidth-1:0] ERR_CLOS_DST        = 6'd26;
    localparam logic [ErrWidth-1:0] ERR_CLOS_WINDOW     = 6'd27;
    localparam logic [ErrWidth-1:0] ERR_CLOS_UPV        = 6'd28;
    localparam logic [ErrWidth-1:0] ERR_UPV_REG         = 6'd29;
    localparam logic [ErrWidth-1:0] ERR_UPV_INDEX       = 6'd30;
    localparam logic [ErrWidth-1:0] ERR_VARARG_FN       = 6'd31;
    localparam logic [ErrWidth-1:0] ERR_VARARG_WINDOW   = 6'd32;
    localparam logic [ErrWidth-1:0] ERR_NEWOBJ          = 6'd33;
    localparam logic [ErrWidth-1:0] ERR_INVOKE          = 6'd34;
    localparam logic [ErrWidth-1:0] ERR_TRY_RANGE       = 6'd35;
    localparam logic [ErrWidth-1:0] ERR_TRY_HANDLER     = 6'd36;
    localparam logic [ErrWidth-1:0] ERR_TRY_END         = 6'd37;

endpackage

>>> hw/rtl/bytecode_operand_checker.sv
// Top level of the bytecode operand checker: configuration registers and the check datapath.
//
// An instruction transfer happens at a rising clock edge where i_start is high and o_busy is
// low. The block never raises o_busy, so one instruction can be transferred in every cycle.
// Each transferred instruction is captured in an input register, checked by combinational
// logic, and its error code and late control flow flag are captured in the result register.
// The result appears with o_valid high for exactly one cycle, after passing through the input
// register and the result register, and results come out in transfer order at one per cycle.
// The configuration channel takes a write whenever i_cfg_valid is high, since o_cfg_ready is
// always high. Registers should be written only while no instruction is in flight.
// A synchronous active-low reset clears the pipeline valid flags and returns the
// configuration registers to their reset values.
// The receiver cannot stall, so no result is ever held back.
module bytecode_operand_checker #(
    parameter int unsigned MAX_INSTRUCTIONS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_start,
    output logic        o_busy,
    input  logic [7:0]  i_command,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [31:0] i_operand_c,
    input  logic [7:0]  i_capture_count,
    input  logic [15:0] i_position,
    input  logic [15:0] i_callee_param_count,
    input  logic        i_callee_is_vararg,
    input  logic [7:0]  i_callee_upvalue_count,
    input  logic        i_constant_is_text,
    input  logic        i_symbol_is_bound,

    output logic        o_valid,
    output logic [5:0]  o_error_code,
    output logic        o_late_control_flow,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam logic [24:0] MaxInst = 25'(MAX_INSTRUCTIONS);

    logic [15:0] r_register_count;
    logic [15:0] r_constant_count;
    logic [15:0] r_function_count;
    logic [16:0] r_instruction_count;
    logic [7:0]  r_own_upvalue_count;
    logic        r_own_is_vararg;
    logic        r_bindings_present;

    logic        r_in_valid;
    logic [7:0]  r_command;
    logic [31:0] r_operand_a;
    logic [31:0] r_operand_b;
    logic [31:0] r_operand_c;
    logic [7:0]  r_capture_count;
    logic [15:0] r_position;
    logic [15:0] r_callee_param_count;
    logic        r_callee_is_vararg;
    logic [7:0]  r_callee_upvalue_count;
    logic        r_constant_is_text;
    logic        r_symbol_is_bound;

    logic        r_out_valid;
    logic [5:0]  r_error_code;
    logic        r_late_control_flow;
    logic [5:0]  n_error_code;
    logic        n_late_control_flow;

    logic [16:0] inst_limit;
    logic        reg_a_ok;
    logic        reg_b_ok;
    logic        reg_c_ok;
    logic        const_b_ok;
    logic        func_b_ok;
    logic        win_ac_ok;
    logic        win_clos_ok;
    logic        win_var_ok;
    logic [32:0] sum_ac;
    logic [32:0] sum_clos;
    logic [32:0] sum_var;
    logic        tgt_a_ok;
    logic        tgt_b_ok;
    logic        tgt_c_ok;
    logic        try_a_ok;
    logic        try_b_ok;
    logic        try_c_ok;
    logic        is_control;
    logic [16:0] pos_next;

    assign o_busy              = 1'b0;
    assign o_cfg_ready         = 1'b1;
    assign o_valid             = r_out_valid;
    assign o_error_code        = r_error_code;
    assign o_late_control_flow = r_late_control_flow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_register_count    <= 16'd1;
            r_constant_count    <= 16'd0;
            r_function_count    <= 16'd1;
            r_instruction_count <= 17'd1;
            r_own_upvalue_count <= 8'd0;
            r_own_is_vararg     <= 1'b0;
            r_bindings_present  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                boc_pkg::CFG_REGISTER_COUNT:    r_register_count    <= i_cfg_data[15:0];
                boc_pkg::CFG_CONSTANT_COUNT:    r_constant_count    <= i_cfg_data[15:0];
                boc_pkg::CFG_FUNCTION_COUNT:    r_function_count    <= i_cfg_data[15:0];
                boc_pkg::CFG_INSTRUCTION_COUNT: r_instruction_count <= i_cfg_data;
                boc_pkg::CFG_OWN_UPVALUE_COUNT: r_own_upvalue_count <= i_cfg_data[7:0];
                boc_pkg::CFG_OWN_IS_VARARG:     r_own_is_vararg     <= i_cfg_data[0];
                boc_pkg::CFG_BINDINGS_PRESENT:  r_bindings_present  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_command              <= i_command;
            r_operand_a            <= i_operand_a;
            r_operand_b            <= i_operand_b;
            r_operand_c            <= i_operand_c;
            r_capture_count        <= i_capture_count;
            r_position             <= i_position;
            r_callee_param_count   <= i_callee_param_count;
            r_callee_is_vararg     <= i_callee_is_vararg;
            r_callee_upvalue_count <= i_callee_upvalue_count;
            r_constant_is_text     <= i_constant_is_text;
            r_symbol_is_bound      <= i_symbol_is_bound;
        end
    end

    // An instruction count above the maximum is clipped to the maximum.
    assign inst_limit = ({8'd0, r_instruction_count} > MaxInst) ? MaxInst[16:0]
                                                                : r_instruction_count;

    assign reg_a_ok   = r_operand_a < {16'd0, r_register_count};
    assign reg_b_ok   = r_operand_b < {16'd0, r_register_count};
    assign reg_c_ok   = r_operand_c < {16'd0, r_register_count};
    assign const_b_ok = r_operand_b < {16'd0, r_constant_count};
    assign func_b_ok  = r_operand_b < {16'd0, r_function_count};

    assign sum_ac   = {1'b0, r_operand_a} + {1'b0, r_operand_c};
    assign sum_clos = {1'b0, r_operand_c} + {25'd0, r_capture_count} - 33'd1;
    assign sum_var  = {1'b0, r_operand_a} + {1'b0, r_operand_c} - 33'd1;

    assign win_ac_ok   = sum_ac < {17'd0, r_register_count};
    assign win_clos_ok = (r_capture_count == 8'd0) || (sum_clos < {17'd0, r_register_count});
    assign win_var_ok  = (r_operand_c == 32'd0) || (sum_var < {17'd0, r_register_count});

    function automatic logic target_ok(input logic [15:0] pos, input logic [31:0] delta,
                                       input logic [16:0] limit);
        logic signed [33:0] next;
        next = $signed({18'd0, pos}) + $signed({{2{delta[31]}}, delta});
        return !next[33] && (next[32:0] < {16'd0, limit});
    endfunction

    assign tgt_a_ok = target_ok(r_position, r_operand_a, inst_limit);
    assign tgt_b_ok = target_ok(r_position, r_operand_b, inst_limit);
    assign tgt_c_ok = target_ok(r_position, r_operand_c, inst_limit);

    assign try_a_ok = (r_operand_a == boc_pkg::NO_TRY_TARGET) || (r_operand_a < {15'd0, inst_limit});
    assign try_b_ok = (r_operand_b == boc_pkg::NO_TRY_TARGET) || (r_operand_b < {15'd0, inst_limit});
    assign try_c_ok = (r_operand_c == boc_pkg::NO_TRY_TARGET) || (r_operand_c < {15'd0, inst_limit});

    always_comb begin
        n_error_code = boc_pkg::ERR_NONE;
        unique case (r_command) inside
            boc_pkg::OP_MOV: begin
                if (!(reg_a_ok && reg_b_ok)) n_error_code = boc_pkg::ERR_MOV;
            end
            boc_pkg::OP_LOADK: begin
                if (!(reg_a_ok && const_b_ok)) n_error_code = boc_pkg::ERR_LOADK;
            end
            [boc_pkg::OP_ADD:boc_pkg::OP_STRCONCAT]: begin
                if (!(reg_a_ok && reg_b_ok && reg_c_ok)) n_error_code = boc_pkg::ERR_ARITH;
            end
            boc_pkg::OP_ADDIMM, boc_pkg::OP_SUBIMM: begin
                if (!(reg_a_ok && reg_b_ok)) n_error_code = boc_pkg::ERR_IMM_ARITH;
            end
            boc_pkg::OP_INC, boc_pkg::OP_DEC: begin
                if (!reg_a_ok) n_error_code = boc_pkg::ERR_INCDEC;
            end
            boc_pkg::OP_STRLEN, boc_pkg::OP_BITNOT: begin
                if (!reg_a_ok) n_error_code = boc_pkg::ERR_INCDEC;
                else if (!reg_b_ok) n_error_code = boc_pkg::ERR_UNARY;
            end
            boc_pkg::OP_RET, boc_pkg::OP_THROW: begin
                if (!reg_a_ok) n_error_code = boc_pkg::ERR_RET_THROW;
            end
            boc_pkg::OP_JMP: begin
                if (!tgt_a_ok) n_error_code = boc_pkg::ERR_JMP_TARGET;
            end
            boc_pkg::OP_JMPIF: begin
                if (!reg_a_ok) n_error_code = boc_pkg::ERR_COND_REG;
                else if (!tgt_b_ok) n_error_code = boc_pkg::ERR_JMPIF_TARGET;
            end
            boc_pkg::OP_JMPIFZERO, boc_pkg::OP_JMPIFNOTZERO: begin
                if (!reg_a_ok) n_error_code = boc_pkg::ERR_COND_REG;
                else if (!tgt_b_ok) n_error_code = boc_pkg::ERR_CONDJ_TARGET;
            end
            boc_pkg::OP_DECJNZ: begin
                if (!reg_a_ok) n_error_code = boc_pkg::ERR_COUNTER_REG;
                else if (!tgt_b_ok) n_error_code = boc_pkg::ERR_DECJNZ_TARGET;
            end
            boc_pkg::OP_ADDDECJNZ: begin
                if (!(reg_a_ok && reg_b_ok)) n_error_code = boc_pkg::ERR_ADJ_REG;
                else if (!tgt_c_ok) n_error_code = boc_pkg::ERR_ADJ_TARGET;
            end
            boc_pkg::OP_SUBIMMJNZ, boc_pkg::OP_ADDIMMJNZ: begin
                if (!reg_a_ok) n_error_code = boc_pkg::ERR_IMMJNZ_REG;
                else if (!tgt_c_ok) n_error_code = boc_pkg::ERR_IMMJNZ_TARGET;
            end
            boc_pkg::OP_CALL, boc_pkg::OP_TAILCALL: begin
                if (!func_b_ok) n_error_code = boc_pkg::ERR_CALL_INDEX;
                else if (!win_ac_ok) n_error_code = boc_pkg::ERR_CALL_WINDOW;
                else if (!r_callee_is_vararg && ({16'd0, r_callee_param_count} != r_operand_c))
                    n_error_code = boc_pkg::ERR_CALL_ARGC;
                else if (r_callee_is_vararg && (r_operand_c < {16'd0, r_callee_param_count}))
                    n_error_code = boc_pkg::ERR_CALL_VARARGC;
            end
            boc_pkg::OP_CALLCLOSURE, boc_pkg::OP_TAILCALLCLOSURE: begin
                if (!(reg_b_ok && win_ac_ok)) n_error_code = boc_pkg::ERR_CLOSCALL_WINDOW;
            end
            boc_pkg::OP_FFICALL: begin
                if (!win_ac_ok) n_error_code = boc_pkg::ERR_FFI_WINDOW;
                else if (!(const_b_ok && r_constant_is_text)) n_error_code = boc_pkg::ERR_FFI_CONST;
                else if (r_bindings_present && !r_symbol_is_bound)
                    n_error_code = boc_pkg::ERR_FFI_SYMBOL;
            end
            boc_pkg::OP_CLOSURE: begin
                if (!(reg_a_ok && func_b_ok)) n_error_code = boc_pkg::ERR_CLOS_DST;
                else if (!win_clos_ok) n_error_code = boc_pkg::ERR_CLOS_WINDOW;
                else if (r_callee_upvalue_count != r_capture_count)
                    n_error_code = boc_pkg::ERR_CLOS_UPV;
            end
            boc_pkg::OP_GETUPVAL, boc_pkg::OP_SETUPVAL: begin
                if (!reg_a_ok) n_error_code = boc_pkg::ERR_UPV_REG;
                else if (!(r_operand_b < {24'd0, r_own_upvalue_count}))
                    n_error_code = boc_pkg::ERR_UPV_INDEX;
            end
            boc_pkg::OP_VARARG: begin
                if (!r_own_is_vararg) n_error_code = boc_pkg::ERR_VARARG_FN;
                else if (!win_var_ok) n_error_code = boc_pkg::ERR_VARARG_WINDOW;
            end
            boc_pkg::OP_NEWOBJECT: begin
                if (!(reg_a_ok && const_b_ok && r_constant_is_text))
                    n_error_code = boc_pkg::ERR_NEWOBJ;
            end
            boc_pkg::OP_INVOKE: begin
                if (!(reg_a_ok && const_b_ok && r_constant_is_text && win_ac_ok))
                    n_error_code = boc_pkg::ERR_INVOKE;
            end
            boc_pkg::OP_TRYBEGIN: begin
                if (!(try_a_ok && try_b_ok && try_c_ok)) n_error_code = boc_pkg::ERR_TRY_RANGE;
                else if ((r_operand_a == boc_pkg::NO_TRY_TARGET)
                         && (r_operand_b == boc_pkg::NO_TRY_TARGET))
                    n_error_code = boc_pkg::ERR_TRY_HANDLER;
                else if (r_operand_c == boc_pkg::NO_TRY_TARGET)
                    n_error_code = boc_pkg::ERR_TRY_END;
            end
            default: begin
                n_error_code = boc_pkg::ERR_NONE;
            end
        endcase
    end

    always_comb begin
        case (r_command) inside
            [boc_pkg::OP_RET:boc_pkg::OP_ADDIMMJNZ],
            boc_pkg::OP_TAILCALL,
            boc_pkg::OP_TAILCALLCLOSURE,
            [boc_pkg::OP_TRYEND:boc_pkg::OP_HALT]: is_control = 1'b1;
            default: is_control = 1'b0;
        endcase
    end

    assign pos_next = {1'b0, r_position} + 17'd1;
    assign n_late_control_flow = (n_error_code == boc_pkg::ERR_NONE) && is_control
                                 && (pos_next < inst_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_error_code        <= n_error_code;
            r_late_control_flow <= n_late_control_flow;
        end
    end

endmodule

>>> tb/operand_rule_checker.sv
// Watches the instruction, result and configuration channels and checks each verdict of the block.
module operand_rule_checker #(
    parameter int unsigned MAX_INSTRUCTIONS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [7:0]  i_command,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [31:0] i_operand_c,
    input  logic [7:0]  i_capture_count,
    input  logic [15:0] i_position,
    input  logic [15:0] i_callee_param_count,
    input  logic        i_callee_is_vararg,
    input  logic [7:0]  i_callee_upvalue_count,
    input  logic        i_constant_is_text,
    input  logic        i_symbol_is_bound,
    input  logic        i_result_valid,
    input  logic [5:0]  i_error_code,
    input  logic        i_late_control_flow,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_due_count
);
    import boc_pkg::*;

    typedef struct packed {
        logic [7:0] op;
        logic [5:0] code;
        logic       late;
    } t_verdict;

    t_verdict verdicts_due[$];

    logic [15:0] reg_limit;
    logic [15:0] const_limit;
    logic [15:0] func_limit;
    logic [16:0] inst_total;
    logic [7:0]  upv_limit;
    logic        fn_vararg;
    logic        have_bindings;

    initial begin
        o_fail_count = 0;
        o_due_count = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic longint inst_cap();
        return (inst_total > MAX_INSTRUCTIONS) ? longint'(MAX_INSTRUCTIONS) : longint'(inst_total);
    endfunction

    function automatic logic reg_fits(input logic [31:0] r);
        return r < reg_limit;
    endfunction

    function automatic logic window_fits(input logic [31:0] base, input logic [31:0] cnt);
        return longint'(base) + longint'(cnt) < longint'(reg_limit);
    endfunction

    function automatic logic lands(input logic [15:0] pos, input logic [31:0] delta);
        longint dest;
        dest = longint'(pos) + longint'($signed(delta));
        return dest >= 0 && dest < inst_cap();
    endfunction

    function automatic logic try_fits(input logic [31:0] t);
        return t == NO_TRY_TARGET || longint'(t) < inst_cap();
    endfunction

    function automatic t_verdict expected_verdict(
        input logic [7:0]  op,
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [7:0]  caps,
        input logic [15:0] pos,
        input logic [15:0] cparams,
        input logic        cvar,
        input logic [7:0]  cupv,
        input logic        text,
        input logic        bound
    );
        logic [5:0] code;
        logic       ctl;
        t_verdict   v;
        code = ERR_NONE;
        if (op >= OP_ADD && op <= OP_STRCONCAT) begin
            if (!(reg_fits(a) && reg_fits(b) && reg_fits(c))) code = ERR_ARITH;
        end else begin
            case (op)
                OP_MOV: if (!(reg_fits(a) && reg_fits(b))) code = ERR_MOV;
                OP_LOADK: if (!(reg_fits(a) && b < const_limit)) code = ERR_LOADK;
                OP_ADDIMM, OP_SUBIMM: if (!(reg_fits(a) && reg_fits(b))) code = ERR_IMM_ARITH;
                OP_INC, OP_DEC, OP_STRLEN, OP_BITNOT: begin
                    if (!reg_fits(a)) code = ERR_INCDEC;
                    else if ((op == OP_STRLEN || op == OP_BITNOT) && !reg_fits(b)) code = ERR_UNARY;
                end
                OP_RET, OP_THROW: if (!reg_fits(a)) code = ERR_RET_THROW;
                OP_JMP: if (!lands(pos, a)) code = ERR_JMP_TARGET;
                OP_JMPIF: begin
                    if (!reg_fits(a)) code = ERR_COND_REG;
                    else if (!lands(pos, b)) code = ERR_JMPIF_TARGET;
                end
                OP_JMPIFZERO, OP_JMPIFNOTZERO: begin
                    if (!reg_fits(a)) code = ERR_COND_REG;
                    else if (!lands(pos, b)) code = ERR_CONDJ_TARGET;
                end
                OP_DECJNZ: begin
                    if (!reg_fits(a)) code = ERR_COUNTER_REG;
                    else if (!lands(pos, b)) code = ERR_DECJNZ_TARGET;
                end
                OP_ADDDECJNZ: begin
                    if (!reg_fits(a) || !reg_fits(b)) code = ERR_ADJ_REG;
                    else if (!lands(pos, c)) code = ERR_ADJ_TARGET;
                end
                OP_SUBIMMJNZ, OP_ADDIMMJNZ: begin
                    if (!reg_fits(a)) code = ERR_IMMJNZ_REG;
                    else if (!lands(pos, c)) code = ERR_IMMJNZ_TARGET;
                end
                OP_CALL, OP_TAILCALL: begin
                    if (b >= func_limit) code = ERR_CALL_INDEX;
                    else if (!window_fits(a, c)) code = ERR_CALL_WINDOW;
                    else if (!cvar && {16'b0, cparams} != c) code = ERR_CALL_ARGC;
                    else if (cvar && c < {16'b0, cparams}) code = ERR_CALL_VARARGC;
                end
                OP_CALLCLOSURE, OP_TAILCALLCLOSURE: begin
                    if (!(reg_fits(b) && window_fits(a, c))) code = ERR_CLOSCALL_WINDOW;
                end
                OP_FFICALL: begin
                    if (!window_fits(a, c)) code = ERR_FFI_WINDOW;
                    else if (b >= const_limit || !text) code = ERR_FFI_CONST;
                    else if (have_bindings && !bound) code = ERR_FFI_SYMBOL;
                end
                OP_CLOSURE: begin
                    if (!reg_fits(a) || b >= func_limit) code = ERR_CLOS_DST;
                    else if (caps != 0 && !window_fits(c, {24'b0, caps} - 32'd1)) begin
                        code = ERR_CLOS_WINDOW;
                    end else if (cupv != caps) code = ERR_CLOS_UPV;
                end
                OP_GETUPVAL, OP_SETUPVAL: begin
                    if (!reg_fits(a)) code = ERR_UPV_REG;
                    else if (!(b < upv_limit)) code = ERR_UPV_INDEX;
                end
                OP_VARARG: begin
                    if (!fn_vararg) code = ERR_VARARG_FN;
                    else if (c != 0 && !window_fits(a, c - 32'd1)) code = ERR_VARARG_WINDOW;
                end
                OP_NEWOBJECT: if (!(reg_fits(a) && b < const_limit && text)) code = ERR_NEWOBJ;
                OP_INVOKE: begin
                    if (!(reg_fits(a) && b < const_limit && text && window_fits(a, c))) begin
                        code = ERR_INVOKE;
                    end
                end
                OP_TRYBEGIN: begin
                    if (!try_fits(a) || !try_fits(b) || !try_fits(c)) code = ERR_TRY_RANGE;
                    else if (a == NO_TRY_TARGET && b == NO_TRY_TARGET) code = ERR_TRY_HANDLER;
                    else if (c == NO_TRY_TARGET) code = ERR_TRY_END;
                end
                default: ;
            endcase
        end
        ctl = (op >= OP_RET && op <= OP_ADDIMMJNZ) || op == OP_TAILCALL
            || op == OP_TAILCALLCLOSURE || (op >= OP_TRYEND && op <= OP_HALT);
        v.op = op;
        v.code = code;
        v.late = (code == ERR_NONE) && ctl && (longint'(pos) + 1 < inst_cap());
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict head;
        if (!i_rst_n) begin
            reg_limit <= 16'd1;
            const_limit <= 16'd0;
            func_limit <= 16'd1;
            inst_total <= 17'd1;
            upv_limit <= 8'd0;
            fn_vararg <= 1'b0;
            have_bindings <= 1'b0;
            verdicts_due.delete();
        end else begin
            if (i_result_valid) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result with no instruction outstanding");
                end else begin
                    head = verdicts_due.pop_front();
                    if (i_error_code != head.code) begin
                        report_mismatch($sformatf("opcode %0d error code %0d, expected %0d",
                                                  head.op, i_error_code, head.code));
                    end
                    if (i_late_control_flow != head.late) begin
                        report_mismatch($sformatf("opcode %0d late flag %0b, expected %0b",
                                                  head.op, i_late_control_flow, head.late));
                    end
                end
            end
            if (i_start && !i_busy) begin
                verdicts_due.push_back(expected_verdict(i_command, i_operand_a, i_operand_b,
                    i_operand_c, i_capture_count, i_position, i_callee_param_count,
                    i_callee_is_vararg, i_callee_upvalue_count, i_constant_is_text,
                    i_symbol_is_bound));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_REGISTER_COUNT:    reg_limit <= i_cfg_data[15:0];
                    CFG_CONSTANT_COUNT:    const_limit <= i_cfg_data[15:0];
                    CFG_FUNCTION_COUNT:    func_limit <= i_cfg_data[15:0];
                    CFG_INSTRUCTION_COUNT: inst_total <= i_cfg_data;
                    CFG_OWN_UPVALUE_COUNT: upv_limit <= i_cfg_data[7:0];
                    CFG_OWN_IS_VARARG:     fn_vararg <= i_cfg_data[0];
                    CFG_BINDINGS_PRESENT:  have_bindings <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_due_count = verdicts_due.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the bytecode operand checker testbench: clock, reset, stimulus and final verdict.
module testbench;
    import boc_pkg::*;

    localparam int unsigned MAX_INSTRUCTIONS = 65536;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 203;
    localparam int DIRECTED_COUNT = 25;
    localparam logic [7:0] OP_UNKNOWN_TOP = 8'hFF;
    localparam logic [DIRECTED_COUNT*8-1:0] DIRECTED_OPS = {
        OP_MOV, OP_LOADK, OP_ADD, OP_STRCONCAT, OP_SUBIMM, OP_DEC, OP_BITNOT, OP_THROW,
        OP_JMP, OP_JMPIF, OP_JMPIFNOTZERO, OP_DECJNZ, OP_ADDDECJNZ, OP_ADDIMMJNZ,
        OP_TAILCALL, OP_TAILCALLCLOSURE, OP_FFICALL, OP_CLOSURE, OP_SETUPVAL, OP_VARARG,
        OP_NEWOBJECT, OP_INVOKE, OP_UNKNOWN_TOP, OP_HALT, OP_TRYBEGIN
    };

    typedef enum logic [1:0] {FORM_SHAPED, FORM_ZEROS, FORM_ONES} t_item_form;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  command;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic [7:0]  capture_count;
    logic [15:0] position;
    logic [15:0] callee_param_count;
    logic        callee_is_vararg;
    logic [7:0]  callee_upvalue_count;
    logic        constant_is_text;
    logic        symbol_is_bound;
    logic        res_valid;
    logic [5:0]  error_code;
    logic        late_flow;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;
    int          fail_count;
    int          due_count;
    int          idle_cycles = 0;

    int unsigned lim_regs;
    int unsigned lim_consts;
    int unsigned lim_funcs;
    int unsigned lim_insts;
    int unsigned lim_upvals;
    logic        gappy;

    bytecode_operand_checker #(
        .MAX_INSTRUCTIONS(MAX_INSTRUCTIONS)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_start(start),
        .o_busy(busy),
        .i_command(command),
        .i_operand_a(operand_a),
        .i_operand_b(operand_b),
        .i_operand_c(operand_c),
        .i_capture_count(capture_count),
        .i_position(position),
        .i_callee_param_count(callee_param_count),
        .i_callee_is_vararg(callee_is_vararg),
        .i_callee_upvalue_count(callee_upvalue_count),
        .i_constant_is_text(constant_is_text),
        .i_symbol_is_bound(symbol_is_bound),
        .o_valid(res_valid),
        .o_error_code(error_code),
        .o_late_control_flow(late_flow),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    operand_rule_checker #(
        .MAX_INSTRUCTIONS(MAX_INSTRUCTIONS)
    ) rules (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_command(command),
        .i_operand_a(operand_a),
        .i_operand_b(operand_b),
        .i_operand_c(operand_c),
        .i_capture_count(capture_count),
        .i_position(position),
        .i_callee_param_count(callee_param_count),
        .i_callee_is_vararg(callee_is_vararg),
        .i_callee_upvalue_count(callee_upvalue_count),
        .i_constant_is_text(constant_is_text),
        .i_symbol_is_bound(symbol_is_bound),
        .i_result_valid(res_valid),
        .i_error_code(error_code),
        .i_late_control_flow(late_flow),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_fail_count(fail_count),
        .o_due_count(due_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int draw_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (!gappy || sel < 12) return 0;
        if (sel < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly an index below the limit, sometimes on or just under the boundary, or anywhere.
    function automatic logic [31:0] pick_index(input longint limit);
        logic [31:0] v;
        if (limit < 0) limit = 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = (limit > 0) ? $urandom_range(0, int'(limit - 1)) : 32'd0;
            6: v = limit[31:0];
            7: v = (limit > 0) ? limit[31:0] - 32'd1 : 32'd0;
            8: v = $urandom;
            default: v = '1;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_delta(input logic [15:0] pos);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom;
        if (sel == 1) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return pick_index(lim_insts) - {16'b0, pos};
    endfunction

    function automatic logic [31:0] pick_try();
        return ($urandom_range(0, 3) == 0) ? NO_TRY_TARGET : pick_index(lim_insts);
    endfunction

    task automatic write_register(input logic [2:0] idx, input int unsigned value,
                                  input int width);
        logic [16:0] data;
        int gap;
        data = value[16:0];
        if (width < 17 && $urandom_range(0, 3) == 0) data |= 17'($urandom) << width;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge clk);
            cfg_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_limits(input int unsigned rc, input int unsigned kc,
                                  input int unsigned fc, input int unsigned ic,
                                  input int unsigned uc, input logic va, input logic bp);
        @(negedge clk);
        start = 1'b0;
        while (due_count != 0) @(negedge clk);
        write_register(CFG_REGISTER_COUNT, rc, 16);
        write_register(CFG_CONSTANT_COUNT, kc, 16);
        write_register(CFG_FUNCTION_COUNT, fc, 16);
        write_register(CFG_INSTRUCTION_COUNT, ic, 17);
        write_register(CFG_OWN_UPVALUE_COUNT, uc, 8);
        write_register(CFG_OWN_IS_VARARG, 32'(va), 1);
        write_register(CFG_BINDINGS_PRESENT, 32'(bp), 1);
        @(negedge clk);
        cfg_valid = 1'b0;
        lim_regs = rc;
        lim_consts = kc;
        lim_funcs = fc;
        lim_insts = (ic > MAX_INSTRUCTIONS) ? MAX_INSTRUCTIONS : ic;
        lim_upvals = uc;
    endtask

    task automatic send_instruction(input logic [7:0] op, input t_item_form form);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        position = 16'(pick_index(lim_insts));
        operand_a = pick_index(lim_regs);
        operand_b = pick_index(lim_regs);
        operand_c = pick_index(lim_regs);
        capture_count = 8'($urandom);
        callee_param_count = 16'($urandom);
        callee_is_vararg = 1'($urandom);
        callee_upvalue_count = 8'($urandom);
        constant_is_text = $urandom_range(0, 4) != 0;
        symbol_is_bound = $urandom_range(0, 4) != 0;
        if (op == OP_JMP) operand_a = pick_delta(position);
        if (op >= OP_JMPIF && op <= OP_DECJNZ) operand_b = pick_delta(position);
        if (op >= OP_ADDDECJNZ && op <= OP_ADDIMMJNZ) operand_c = pick_delta(position);
        case (op)
            OP_LOADK, OP_NEWOBJECT: operand_b = pick_index(lim_consts);
            OP_FFICALL, OP_INVOKE: begin
                operand_b = pick_index(lim_consts);
                operand_c = pick_index(longint'(lim_regs) - longint'(operand_a));
            end
            OP_CALL, OP_TAILCALL: begin
                operand_b = pick_index(lim_funcs);
                operand_c = pick_index(longint'(lim_regs) - longint'(operand_a));
                case ($urandom_range(0, 4))
                    0, 1, 2: callee_param_count = operand_c[15:0];
                    3: callee_param_count = operand_c[15:0] + 16'($urandom_range(0, 2)) - 16'd1;
                    default: ;
                endcase
            end
            OP_CALLCLOSURE, OP_TAILCALLCLOSURE: begin
                operand_c = pick_index(longint'(lim_regs) - longint'(operand_a));
            end
            OP_CLOSURE: begin
                operand_b = pick_index(lim_funcs);
                if ($urandom_range(0, 3) != 0) capture_count = 8'($urandom_range(0, 8));
                operand_c = pick_index(longint'(lim_regs) + 1 - longint'(capture_count));
                if ($urandom_range(0, 4) != 0) callee_upvalue_count = capture_count;
            end
            OP_GETUPVAL, OP_SETUPVAL: operand_b = pick_index(lim_upvals);
            OP_VARARG: operand_c = pick_index(longint'(lim_regs) + 1 - longint'(operand_a));
            OP_TRYBEGIN: begin
                operand_a = pick_try();
                operand_b = pick_try();
                operand_c = pick_try();
            end
            default: ;
        endcase
        if (form != FORM_SHAPED) begin
            position = (form == FORM_ONES) ? '1 : '0;
            operand_a = (form == FORM_ONES) ? '1 : '0;
            operand_b = (form == FORM_ONES) ? '1 : '0;
            operand_c = (form == FORM_ONES) ? '1 : '0;
            capture_count = (form == FORM_ONES) ? '1 : '0;
            callee_param_count = (form == FORM_ONES) ? '1 : '0;
            callee_is_vararg = form == FORM_ONES;
            callee_upvalue_count = (form == FORM_ONES) ? '1 : '0;
            constant_is_text = form == FORM_ONES;
            symbol_is_bound = form == FORM_ONES;
        end
        command = op;
        start = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial begin : stimulus
        t_item_form form;
        logic [7:0] op;
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        operand_a = '0;
        operand_b = '0;
        operand_c = '0;
        capture_count = '0;
        position = '0;
        callee_param_count = '0;
        callee_is_vararg = 1'b0;
        callee_upvalue_count = '0;
        constant_is_text = 1'b0;
        symbol_is_bound = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gappy = 1'b1;
        lim_regs = 1;
        lim_consts = 0;
        lim_funcs = 1;
        lim_insts = 1;
        lim_upvals = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        program_limits(16, 8, 4, 32, 4, 1'b1, 1'b1);
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            form = FORM_SHAPED;
            if (i == 0) form = FORM_ZEROS;
            if (i == DIRECTED_COUNT - 1) form = FORM_ONES;
            send_instruction(DIRECTED_OPS[8*(DIRECTED_COUNT-1-i) +: 8], form);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: program_limits(0, 0, 0, 0, 0, 1'b0, 1'b0);
                1: program_limits(65535, 65535, 65535, 131071, 255, 1'b1, 1'b1);
                2: program_limits($urandom_range(1, 64), $urandom_range(0, 32),
                                  $urandom_range(1, 16), MAX_INSTRUCTIONS,
                                  $urandom_range(0, 16), 1'($urandom), 1'($urandom));
                3: program_limits($urandom_range(1, 64), $urandom_range(0, 32),
                                  $urandom_range(1, 16), MAX_INSTRUCTIONS + 1,
                                  $urandom_range(0, 16), 1'($urandom), 1'($urandom));
                default: program_limits($urandom_range(1, 64), $urandom_range(0, 32),
                                        $urandom_range(1, 16),
                                        ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                                    : $urandom_range(8, 400),
                                        $urandom_range(0, 16), 1'($urandom), 1'($urandom));
            endcase
            gappy = (phase % 3) != 2;
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    op = 8'($urandom_range(OP_HALT + 1, OP_UNKNOWN_TOP));
                end else begin
                    op = 8'($urandom_range(OP_MOV, OP_HALT));
                end
                send_instruction(op, FORM_SHAPED);
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (due_count != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/boc_pkg.sv
hw/rtl/bytecode_operand_checker.sv
tb/operand_rule_checker.sv
tb/testbench.sv
